>>> hdl/sensor_dump_edge_reporter_core_defines.svh
// Assertion macros used by the sensor dump edge reporter back end.
`ifndef SENSOR_DUMP_EDGE_REPORTER_CORE_DEFINES_SVH
`define SENSOR_DUMP_EDGE_REPORTER_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define SDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sdr_pkg.sv
// Shared types, constants and helpers of the sensor dump edge reporter.
`default_nettype none
package sdr_pkg;

  localparam int unsigned DUMP_BYTES_DEF   = 10;
  localparam int unsigned SENSORS_PER_BANK = 16;
  localparam int unsigned HALF_BANK        = SENSORS_PER_BANK / 2;
  localparam int unsigned IDX_W            = 4;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned BIT_W            = 3;
  localparam int unsigned BANK_W           = 3;
  localparam int unsigned NUM_W            = 5;
  localparam int unsigned FLAT_W           = 7;
  localparam int unsigned HCNT_W           = 2;
  localparam int unsigned FIFO_DEPTH       = 2;

  typedef struct packed {
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] sensor_byte;
  } sdr_in_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [NUM_W-1:0]  sensor_number;
    logic [FLAT_W-1:0] sensor_index;
    logic [FLAT_W-1:0] previous_index;
    logic              previous_valid;
    logic              last_event;
  } sdr_out_t;

  typedef struct packed {
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] rise_mask;
  } sdr_job_t;

  function automatic logic [NUM_W-1:0] number_in_bank(input logic odd_byte,
                                                      input logic [BIT_W-1:0] bitpos);
    logic [NUM_W-1:0] base;
    base = odd_byte ? NUM_W'(SENSORS_PER_BANK) : NUM_W'(HALF_BANK);
    return base - {{(NUM_W-BIT_W){1'b0}}, bitpos};
  endfunction

endpackage
`default_nettype wire

>>> hdl/sensor_dump_edge_reporter_core.sv
// Sensor dump edge reporter: top level joining front end, job queue and back end.
//
// Accepts one dump byte per cycle while full is low; the front end compares it
// with the stored levels and queues a job only when some bit rises. The back end
// emits one result per rising bit, lowest bit first, through a single output
// register, one per cycle while that register is free or popped; a byte has up
// to 8 rising bits, and bytes with no rising bit never reach the back end. The
// two-entry job queue lets input continue while the back end works or the
// result side stalls.
`default_nettype none
module sensor_dump_edge_reporter_core #(
  parameter int unsigned DUMP_BYTES = sdr_pkg::DUMP_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire sdr_pkg::sdr_in_t in_item,
  output logic                  empty,
  input  wire logic             pop,
  output sdr_pkg::sdr_out_t     out_item
);

  logic              job_push;
  logic              job_full;
  sdr_pkg::sdr_job_t job_in;
  logic              job_pop;
  logic              job_valid;
  sdr_pkg::sdr_job_t job_out;

  sdr_front #(
    .DUMP_BYTES(DUMP_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job_in)
  );

  sdr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (job_push),
    .wr_data  (job_in),
    .wr_full  (job_full),
    .rd_en    (job_pop),
    .rd_valid (job_valid),
    .rd_data  (job_out)
  );

  sdr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> hdl/sdr_front.sv
// Front end: level store, rising edge detection and job issue.
`default_nettype none
module sdr_front #(
  parameter int unsigned DUMP_BYTES = sdr_pkg::DUMP_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire sdr_pkg::sdr_in_t in_item,
  output logic                 job_push,
  input  wire logic            job_full,
  output sdr_pkg::sdr_job_t    job
);

  localparam int unsigned LVL_AW = (DUMP_BYTES > 1) ? $clog2(DUMP_BYTES) : 1;

  logic [sdr_pkg::BYTE_W-1:0] levels_r [DUMP_BYTES];
  logic                       accept;
  logic                       in_range;
  logic [LVL_AW-1:0]          addr;
  logic [sdr_pkg::BYTE_W-1:0] old_level;

  assign full      = job_full;
  assign accept    = push && !job_full;
  assign in_range  = {1'b0, in_item.byte_index} < (sdr_pkg::IDX_W + 1)'(DUMP_BYTES);
  assign addr      = in_item.byte_index[LVL_AW-1:0];
  assign old_level = levels_r[addr];

  always_comb begin
    job.byte_index = in_item.byte_index;
    job.rise_mask  = in_item.sensor_byte & ~old_level;
    job_push       = accept && in_range && (job.rise_mask != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DUMP_BYTES; i++) begin
        levels_r[i] <= '0;
      end
    end else if (accept && in_range) begin
      levels_r[addr] <= in_item.sensor_byte;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sdr_fifo.sv
// Short job queue between front and back end.
`default_nettype none
module sdr_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire sdr_pkg::sdr_job_t wr_data,
  output logic                   wr_full,
  input  wire logic              rd_en,
  output logic                   rd_valid,
  output sdr_pkg::sdr_job_t      rd_data
);

  localparam int unsigned DEPTH = sdr_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sdr_pkg::sdr_job_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign wr_full  = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !wr_full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sdr_back.sv
// Back end: event walk over rising bits, trigger history and result register.
`default_nettype none
`include "sensor_dump_edge_reporter_core_defines.svh"
module sdr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  wire sdr_pkg::sdr_job_t job,
  output logic                   job_pop,
  output logic                   empty,
  input  wire logic              pop,
  output sdr_pkg::sdr_out_t      out_item
);

  logic                          cur_valid_r, cur_valid_nxt;
  logic [sdr_pkg::IDX_W-1:0]     cur_idx_r, cur_idx_nxt;
  logic [sdr_pkg::BYTE_W-1:0]    cur_mask_r, cur_mask_nxt;
  logic [sdr_pkg::FLAT_W-1:0]    hist0_r, hist0_nxt;
  logic [sdr_pkg::FLAT_W-1:0]    hist1_r, hist1_nxt;
  logic [sdr_pkg::HCNT_W-1:0]    hcnt_r, hcnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  sdr_pkg::sdr_out_t             out_r, out_nxt;

  logic [sdr_pkg::BIT_W-1:0]     bitpos;
  logic [sdr_pkg::BYTE_W-1:0]    lowbit;
  logic [sdr_pkg::BYTE_W-1:0]    rem_mask;
  logic [sdr_pkg::FLAT_W-1:0]    flat;
  logic [sdr_pkg::FLAT_W-1:0]    prev;
  logic                          pvalid;
  logic                          out_free;
  logic                          emit;
  logic                          cur_done;

  assign empty    = !out_valid_r;
  assign out_item = out_r;
  assign out_free = !out_valid_r || pop;
  assign emit     = cur_valid_r && out_free;
  assign lowbit   = cur_mask_r & (~cur_mask_r + 1'b1);
  assign rem_mask = cur_mask_r & ~lowbit;
  assign cur_done = emit && (rem_mask == '0);
  assign job_pop  = job_valid && (!cur_valid_r || cur_done);
  assign flat     = {cur_idx_r, bitpos};

  always_comb begin
    bitpos = '0;
    for (int i = sdr_pkg::BYTE_W - 1; i >= 0; i--) begin
      if (cur_mask_r[i]) begin
        bitpos = sdr_pkg::BIT_W'(i);
      end
    end
  end

  // advance history on each emitted event
  always_comb begin
    hist0_nxt = hist0_r;
    hist1_nxt = hist1_r;
    hcnt_nxt  = hcnt_r;
    prev      = '0;
    pvalid    = 1'b0;
    if (emit) begin
      case (hcnt_r)
        2'd0: begin
          hist0_nxt = flat;
          hcnt_nxt  = 2'd1;
        end
        2'd1: begin
          hist1_nxt = flat;
          hcnt_nxt  = 2'd2;
          prev      = hist0_r;
          pvalid    = 1'b1;
        end
        default: begin
          hist0_nxt = hist1_r;
          hist1_nxt = flat;
          prev      = hist1_r;
          pvalid    = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_idx_nxt   = cur_idx_r;
    cur_mask_nxt  = cur_mask_r;
    if (emit) begin
      cur_mask_nxt = rem_mask;
    end
    if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end
    if (job_pop) begin
      cur_valid_nxt = 1'b1;
      cur_idx_nxt   = job.byte_index;
      cur_mask_nxt  = job.rise_mask;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (pop) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_nxt.bank           = cur_idx_r[sdr_pkg::IDX_W-1:1];
      out_nxt.sensor_number  = sdr_pkg::number_in_bank(cur_idx_r[0], bitpos);
      out_nxt.sensor_index   = flat;
      out_nxt.previous_index = prev;
      out_nxt.previous_valid = pvalid;
      out_nxt.last_event     = (rem_mask == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      hist0_r     <= '0;
      hist1_r     <= '0;
      hcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      hist0_r     <= hist0_nxt;
      hist1_r     <= hist1_nxt;
      hcnt_r      <= hcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r  <= cur_idx_nxt;
    cur_mask_r <= cur_mask_nxt;
    out_r      <= out_nxt;
  end

  `SDR_ASSERT_NOW(a_cur_has_bits, cur_valid_r, cur_mask_r != '0, "active job with no rising bits")
  `SDR_ASSERT_NOW(a_hcnt_range, 1'b1, hcnt_r <= 2'd2, "history count above two")
  `SDR_ASSERT_NOW(a_prev_zero, out_valid_r && !out_r.previous_valid,
    out_r.previous_index == '0, "previous index set without history")
  `SDR_ASSERT_NEXT(a_emit_shows, emit, out_valid_r, "emitted event not registered")

endmodule
`default_nettype wire
